### hdl/obm_pkg.sv
// Shared types, codes and constants of the 1-Wire bus master.
package obm_pkg;

   // Default width of the microsecond tick counter.
   localparam int COUNT_BITS_DEFAULT = 10;

   // Configuration port geometry.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 10;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RISE_TIMEOUT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PRES_TIMEOUT  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PRES_MAX      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RESET_RECOV   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SLOT_LOW      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SLOT_SAMPLE   = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SLOT_LENGTH   = 3'd7;

   // Register reset values.
   localparam logic [9:0] RESET_LOW_INIT     = 10'd480;
   localparam logic [9:0] RISE_TIMEOUT_INIT  = 10'd80;
   localparam logic [9:0] PRES_TIMEOUT_INIT  = 10'd80;
   localparam logic [9:0] PRES_MAX_INIT      = 10'd320;
   localparam logic [9:0] RESET_RECOV_INIT   = 10'd240;
   localparam logic [5:0] SLOT_LOW_INIT      = 6'd2;
   localparam logic [6:0] SLOT_SAMPLE_INIT   = 7'd15;
   localparam logic [7:0] SLOT_LENGTH_INIT   = 8'd61;

   // Request mode codes as they arrive on the bus.
   localparam logic [1:0] MODE_RESET = 2'd1;
   localparam logic [1:0] MODE_BYTE  = 2'd2;

   // Shortest bit slot the engine runs.
   localparam logic [7:0] SLOT_LENGTH_MIN = 8'd2;

   // Classified command handed from the front end to the engine.
   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_RESET,
      CMD_BYTE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   tx_byte;
      logic         line_level;
   } cmd_type;

   // Reset outcome codes.
   typedef enum logic [1:0] {
      ST_OK,
      ST_STUCK_LOW,
      ST_NO_PRESENCE,
      ST_PRESENCE_LONG
   } status_type;

   // Engine phases.
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_RISE,
      PH_RST_PRES,
      PH_RST_PEND,
      PH_RST_RECOV,
      PH_SLOT
   } phase_type;

   // One result per tick.
   typedef struct packed {
      status_type  reset_status;
      logic [7:0]  rx_byte;
      logic        done_was_reset;
      logic        done_res;
      logic        busy_res;
      logic        drive_low;
   } rsp_type;

endpackage

### hdl/obm_queue.sv
// Two-entry first-in first-out queue used between the pipeline parts.
module obm_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/obm_front.sv
// Front end: accepts request transactions and classifies their mode.
module obm_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   input  logic [7:0]           req_tx_byte,
   input  logic                 req_line_level,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output obm_pkg::cmd_type     cmd
);

   assign cmd_valid = req_valid;
   assign req_ready = cmd_ready;

   // Decode the mode; the other codes act as a plain tick.
   always_comb begin
      cmd.tx_byte    = req_tx_byte;
      cmd.line_level = req_line_level;
      unique case (req_mode)
         obm_pkg::MODE_RESET: cmd.kind = obm_pkg::CMD_RESET;
         obm_pkg::MODE_BYTE:  cmd.kind = obm_pkg::CMD_BYTE;
         default:             cmd.kind = obm_pkg::CMD_TICK;
      endcase
   end

endmodule

### hdl/obm_engine.sv
// Back end: configuration registers and the 1-Wire timing engine.
module obm_engine #(
   parameter int COUNT_BITS = obm_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [obm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [obm_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                 cmd_valid,
   output logic                                 cmd_ready,
   input  obm_pkg::cmd_type                     cmd,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output obm_pkg::rsp_type                     out
);

   // Compare width wide enough for both the counter and the 10-bit limits.
   localparam int CW = (COUNT_BITS > obm_pkg::CSR_DATA_BITS) ?
                       COUNT_BITS : obm_pkg::CSR_DATA_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   // Configuration registers.
   logic [9:0] cfg_reset_low_ff;
   logic [9:0] cfg_rise_timeout_ff;
   logic [9:0] cfg_pres_timeout_ff;
   logic [9:0] cfg_pres_max_ff;
   logic [9:0] cfg_reset_recov_ff;
   logic [5:0] cfg_slot_low_ff;
   logic [6:0] cfg_slot_sample_ff;
   logic [7:0] cfg_slot_length_ff;

   // Engine state.
   obm_pkg::phase_type      phase_ff, phase_in, phase_eff;
   logic [COUNT_BITS-1:0]   tick_ff, tick_in, tick_eff, tick_inc;
   logic [2:0]              bit_ff, bit_in, bit_eff;
   logic [7:0]              send_ff, send_in, send_eff;
   logic [7:0]              recv_ff, recv_in, recv_eff;
   obm_pkg::status_type     status_ff, status_in;

   // Slot timing derived from the registers.
   logic [7:0] slot_len;
   logic [7:0] slot_last;
   logic [7:0] slot_samp;
   logic [CW-1:0] tick_inc_w;

   logic step;

   assign step      = cmd_valid && out_ready;
   assign cmd_ready = out_ready;
   assign out_valid = cmd_valid;

   // Threshold cut to the counter maximum.
   function automatic logic [CW-1:0] limit_of(input logic [9:0] v);
      logic [CW-1:0] v_w;
      logic [CW-1:0] m_w;
      v_w = CW'(v);
      m_w = CW'(CNT_MAX);
      return (v_w > m_w) ? m_w : v_w;
   endfunction

   assign tick_inc   = (tick_eff != CNT_MAX) ? tick_eff + 1'b1 : tick_eff;
   assign tick_inc_w = CW'(tick_inc);

   assign slot_len  = (cfg_slot_length_ff < obm_pkg::SLOT_LENGTH_MIN) ?
                      obm_pkg::SLOT_LENGTH_MIN : cfg_slot_length_ff;
   assign slot_last = slot_len - 8'd1;
   assign slot_samp = ({1'b0, cfg_slot_sample_ff} < slot_last) ?
                      {1'b0, cfg_slot_sample_ff} : slot_last;

   // Configuration writes, truncated to each register's width.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_reset_low_ff    <= obm_pkg::RESET_LOW_INIT;
         cfg_rise_timeout_ff <= obm_pkg::RISE_TIMEOUT_INIT;
         cfg_pres_timeout_ff <= obm_pkg::PRES_TIMEOUT_INIT;
         cfg_pres_max_ff     <= obm_pkg::PRES_MAX_INIT;
         cfg_reset_recov_ff  <= obm_pkg::RESET_RECOV_INIT;
         cfg_slot_low_ff     <= obm_pkg::SLOT_LOW_INIT;
         cfg_slot_sample_ff  <= obm_pkg::SLOT_SAMPLE_INIT;
         cfg_slot_length_ff  <= obm_pkg::SLOT_LENGTH_INIT;
      end else if (csr_write) begin
         unique case (csr_index)
            obm_pkg::REG_RESET_LOW:    cfg_reset_low_ff    <= csr_data;
            obm_pkg::REG_RISE_TIMEOUT: cfg_rise_timeout_ff <= csr_data;
            obm_pkg::REG_PRES_TIMEOUT: cfg_pres_timeout_ff <= csr_data;
            obm_pkg::REG_PRES_MAX:     cfg_pres_max_ff     <= csr_data;
            obm_pkg::REG_RESET_RECOV:  cfg_reset_recov_ff  <= csr_data;
            obm_pkg::REG_SLOT_LOW:     cfg_slot_low_ff     <= csr_data[5:0];
            obm_pkg::REG_SLOT_SAMPLE:  cfg_slot_sample_ff  <= csr_data[6:0];
            obm_pkg::REG_SLOT_LENGTH:  cfg_slot_length_ff  <= csr_data[7:0];
         endcase
      end
   end

   // Phase register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= obm_pkg::PH_IDLE;
      end else if (step) begin
         phase_ff <= phase_in;
      end
   end

   // Counters, shift registers and status.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         bit_ff    <= 3'd0;
         send_ff   <= 8'd0;
         recv_ff   <= 8'd0;
         status_ff <= obm_pkg::ST_OK;
      end else if (step) begin
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         send_ff   <= send_in;
         recv_ff   <= recv_in;
         status_ff <= status_in;
      end
   end

   // A command starts its operation on its own tick.
   always_comb begin
      phase_eff = phase_ff;
      tick_eff  = tick_ff;
      bit_eff   = bit_ff;
      send_eff  = send_ff;
      recv_eff  = recv_ff;
      if (phase_ff == obm_pkg::PH_IDLE) begin
         if (cmd.kind == obm_pkg::CMD_RESET) begin
            phase_eff = obm_pkg::PH_RST_LOW;
            tick_eff  = '0;
         end else if (cmd.kind == obm_pkg::CMD_BYTE) begin
            phase_eff = obm_pkg::PH_SLOT;
            tick_eff  = '0;
            bit_eff   = 3'd0;
            send_eff  = cmd.tx_byte;
            recv_eff  = 8'd0;
         end
      end
   end

   // Next state and the tick's outputs.
   always_comb begin
      phase_in  = phase_eff;
      tick_in   = tick_eff;
      bit_in    = bit_eff;
      send_in   = send_eff;
      recv_in   = recv_eff;
      status_in = status_ff;
      out.drive_low      = 1'b0;
      out.busy_res       = 1'b0;
      out.done_res       = 1'b0;
      out.done_was_reset = 1'b0;
      unique case (phase_eff)
         obm_pkg::PH_RST_LOW: begin
            out.busy_res  = 1'b1;
            out.drive_low = 1'b1;
            tick_in       = tick_inc;
            if (tick_inc_w >= limit_of(cfg_reset_low_ff)) begin
               phase_in = obm_pkg::PH_RST_RISE;
               tick_in  = '0;
            end
         end
         obm_pkg::PH_RST_RISE: begin
            out.busy_res = 1'b1;
            if (cmd.line_level) begin
               phase_in = obm_pkg::PH_RST_PRES;
               tick_in  = '0;
            end else begin
               tick_in = tick_inc;
               if (tick_inc_w >= limit_of(cfg_rise_timeout_ff)) begin
                  status_in = obm_pkg::ST_STUCK_LOW;
                  phase_in  = obm_pkg::PH_RST_RECOV;
                  tick_in   = '0;
               end
            end
         end
         obm_pkg::PH_RST_PRES: begin
            out.busy_res = 1'b1;
            if (!cmd.line_level) begin
               phase_in = obm_pkg::PH_RST_PEND;
               tick_in  = '0;
            end else begin
               tick_in = tick_inc;
               if (tick_inc_w >= limit_of(cfg_pres_timeout_ff)) begin
                  status_in = obm_pkg::ST_NO_PRESENCE;
                  phase_in  = obm_pkg::PH_RST_RECOV;
                  tick_in   = '0;
               end
            end
         end
         obm_pkg::PH_RST_PEND: begin
            out.busy_res = 1'b1;
            if (cmd.line_level) begin
               status_in = obm_pkg::ST_OK;
               phase_in  = obm_pkg::PH_RST_RECOV;
               tick_in   = '0;
            end else begin
               tick_in = tick_inc;
               if (tick_inc_w >= limit_of(cfg_pres_max_ff)) begin
                  status_in = obm_pkg::ST_PRESENCE_LONG;
                  phase_in  = obm_pkg::PH_RST_RECOV;
                  tick_in   = '0;
               end
            end
         end
         obm_pkg::PH_RST_RECOV: begin
            out.busy_res = 1'b1;
            tick_in      = tick_inc;
            if (tick_inc_w >= limit_of(cfg_reset_recov_ff)) begin
               out.done_res       = 1'b1;
               out.done_was_reset = 1'b1;
               phase_in           = obm_pkg::PH_IDLE;
               tick_in            = '0;
            end
         end
         obm_pkg::PH_SLOT: begin
            out.busy_res = 1'b1;
            // Pull low at slot start, then release to the transmit bit.
            if (tick_eff < COUNT_BITS'(slot_last)) begin
               if (tick_eff < COUNT_BITS'(cfg_slot_low_ff)) begin
                  out.drive_low = 1'b1;
               end else begin
                  out.drive_low = !send_eff[0];
               end
            end
            if (tick_eff == COUNT_BITS'(slot_samp)) begin
               recv_in = {cmd.line_level, recv_eff[7:1]};
            end
            if (tick_eff >= COUNT_BITS'(slot_last)) begin
               send_in = {1'b0, send_eff[7:1]};
               tick_in = '0;
               if (bit_eff == 3'd7) begin
                  bit_in       = 3'd0;
                  out.done_res = 1'b1;
                  phase_in     = obm_pkg::PH_IDLE;
               end else begin
                  bit_in = bit_eff + 3'd1;
               end
            end else begin
               tick_in = tick_eff + 1'b1;
            end
         end
         default: begin
            phase_in = obm_pkg::PH_IDLE;
            tick_in  = '0;
         end
      endcase
      out.rx_byte      = recv_in;
      out.reset_status = status_in;
   end

endmodule

### hdl/onewire_bus_master_unit.sv
// Top level of the 1-Wire bus master: front end, command queue, engine, result queue.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tdata: tx_byte, line_level; tuser: mode
//   rsp      out        rsp_tvalid/rsp_tready  tdata: one result per tick
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// The engine answers each tick combinationally; a new request is taken every cycle
// while the command queue has room, and reaches its result through both queues.
// Reset is synchronous and clears the queues, the engine and the registers.
// Either side may stall; two-entry queues on both sides of the engine absorb it.
module onewire_bus_master_unit #(
   parameter int COUNT_BITS = obm_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // tx_byte[7:0], line_level[8], zero
   input  logic [1:0]                          req_tuser,  // mode[1:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,  // drive_low, busy_res, done_res,
                                                           // done_was_reset, rx_byte[11:4],
                                                           // reset_status[13:12], zero
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [obm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [obm_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int CMD_BITS = $bits(obm_pkg::cmd_type);
   localparam int RSP_BITS = $bits(obm_pkg::rsp_type);

   obm_pkg::cmd_type  front_cmd;
   obm_pkg::cmd_type  queue_cmd;
   obm_pkg::rsp_type  engine_rsp;
   obm_pkg::rsp_type  queue_rsp;
   logic              front_valid, front_ready;
   logic              cmd_valid, cmd_ready;
   logic              eng_valid, eng_ready;

   assign csr_ready = 1'b1;

   // Classify each request transaction.
   obm_front u_front (
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_mode       (req_tuser),
      .req_tx_byte    (req_tdata[7:0]),
      .req_line_level (req_tdata[8]),
      .cmd_valid      (front_valid),
      .cmd_ready      (front_ready),
      .cmd            (front_cmd)
   );

   // Command queue between front end and engine.
   obm_queue #(.WIDTH(CMD_BITS)) u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_ready),
      .pop_data   (queue_cmd)
   );

   // Timing engine.
   obm_engine #(.COUNT_BITS(COUNT_BITS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (queue_cmd),
      .out_valid (eng_valid),
      .out_ready (eng_ready),
      .out       (engine_rsp)
   );

   // Result queue toward the response channel.
   obm_queue #(.WIDTH(RSP_BITS)) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (eng_valid),
      .push_ready (eng_ready),
      .push_data  (engine_rsp),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (queue_rsp)
   );

   // Pack the result fields, lowest bit first.
   assign rsp_tdata = {2'b00, queue_rsp};

endmodule

### hdl/obm_checker.sv
// Port-level checks of the 1-Wire bus master and their binding to the top level.
module obm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A result waiting to be taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result transaction withdrawn while stalled");

   // Finishing tick is always a busy tick.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1])
      else $error("done without busy");

   // Reset completion flag only with done.
   a_reset_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2])
      else $error("done_was_reset without done");

   // The line is only pulled while an operation runs.
   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("line driven while idle");

endmodule

bind onewire_bus_master_unit obm_checker u_obm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
